FILE: design/glc_pkg.sv
`timescale 1ns / 1ps

package glc_pkg;

	// Width of one fixed-point coordinate and of a write cell index.
	localparam int COORD_W = 14;
	localparam int CELL_W  = 6;

	// Item opcodes.
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_INIT,
		ST_WALK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic write;
		logic load;
		logic prep;
		logic init;
		logic step;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic hit_visible;
		logic hit_blocked;
		logic exhausted;
	} dp_sts_t;

endpackage

FILE: design/glc_req_if.sv
`timescale 1ns / 1ps

interface glc_req_if import glc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [CELL_W-1:0]  cell_x;
	logic [CELL_W-1:0]  cell_y;
	logic               wall_flag;
	logic [COORD_W-1:0] from_x;
	logic [COORD_W-1:0] from_y;
	logic [COORD_W-1:0] to_x;
	logic [COORD_W-1:0] to_y;

	modport source (
		output valid, opcode, cell_x, cell_y, wall_flag, from_x, from_y, to_x, to_y,
		input  ready
	);

	modport sink (
		input  valid, opcode, cell_x, cell_y, wall_flag, from_x, from_y, to_x, to_y,
		output ready
	);
endinterface

FILE: design/glc_rsp_if.sv
`timescale 1ns / 1ps

interface glc_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (
		output valid, visible,
		input  ready
	);

	modport sink (
		input  valid, visible,
		output ready
	);
endinterface

FILE: design/glc_ram.sv
`timescale 1ns / 1ps

module glc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/glc_dp.sv
`timescale 1ns / 1ps

module glc_dp import glc_pkg::*; #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int FRAC_BITS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [CELL_W-1:0]  cell_x,
	input  logic [CELL_W-1:0]  cell_y,
	input  logic               wall_flag,
	input  logic [COORD_W-1:0] from_x,
	input  logic [COORD_W-1:0] from_y,
	input  logic [COORD_W-1:0] to_x,
	input  logic [COORD_W-1:0] to_y,
	output dp_sts_t            sts
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(GRID_WIDTH);
	localparam int YW    = $clog2(GRID_HEIGHT);
	// Signed difference, Manhattan distance, product and remainder widths.
	// The remainder must hold the divisor plus one axis difference with its sign.
	localparam int DW    = COORD_W + 1;
	localparam int MW    = COORD_W + 1;
	localparam int PW    = COORD_W + MW;
	localparam int RW    = MW + FRAC_BITS + 2;

	localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((1 << FRAC_BITS) - 1);
	localparam logic [COORD_W-1:0] GW        = COORD_W'(GRID_WIDTH);
	localparam logic [COORD_W-1:0] GH        = COORD_W'(GRID_HEIGHT);

	// Query registers.
	logic [COORD_W-1:0]   fx_q, fy_q, ex_q, ey_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [MW-1:0]        m_q, n_q, k_q;
	logic signed [RW-1:0] dxm_q, dxp_q, dym_q, dyp_q;
	logic signed [RW-1:0] rx_q, ry_q;
	logic [COORD_W-1:0]   cx_q, cy_q;
	logic                 pt_valid_q;
	logic                 chk_valid_s1, end_hit_s1, inrange_s1;
	logic [AW-1:0]        clr_q;

	logic [MW-1:0]        ax, ay;
	logic [COORD_W-1:0]   frac_x, frac_y;
	logic [PW-1:0]        prod_x, prod_y;
	logic signed [RW-1:0] d_val, dx_ext, dy_ext;
	logic signed [RW-1:0] rxa, rxb, rxc, rya, ryb, ryc;
	logic                 adv;
	logic [COORD_W-1:0]   wx, wy;
	logic                 wr_ok;
	logic                 ram_we, ram_wdata, ram_rdata;
	logic [AW-1:0]        ram_waddr, ram_raddr;

	// Setup arithmetic.
	assign ax     = dx_q[DW-1] ? MW'(-dx_q) : MW'(dx_q);
	assign ay     = dy_q[DW-1] ? MW'(-dy_q) : MW'(dy_q);
	assign frac_x = fx_q & FRAC_MASK;
	assign frac_y = fy_q & FRAC_MASK;
	assign prod_x = PW'(frac_x) * PW'(m_q);
	assign prod_y = PW'(frac_y) * PW'(m_q);
	assign d_val  = RW'(m_q) << FRAC_BITS;
	assign dx_ext = RW'(dx_q);
	assign dy_ext = RW'(dy_q);

	// Remainder update candidates: stay, carry up, borrow down.
	assign rxa = rx_q + dx_ext;
	assign rxb = rx_q + dxm_q;
	assign rxc = rx_q + dxp_q;
	assign rya = ry_q + dy_ext;
	assign ryb = ry_q + dym_q;
	assign ryc = ry_q + dyp_q;
	assign adv = cmd.step && (k_q < n_q);

	// Capture the query and walk the ray one point per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fx_q <= from_x;
			fy_q <= from_y;
			ex_q <= to_x >> FRAC_BITS;
			ey_q <= to_y >> FRAC_BITS;
			dx_q <= DW'(signed'({1'b0, to_x})) - DW'(signed'({1'b0, from_x}));
			dy_q <= DW'(signed'({1'b0, to_y})) - DW'(signed'({1'b0, from_y}));
		end
		if (cmd.prep) begin
			m_q <= ax + ay;
		end
		if (cmd.init) begin
			rx_q  <= RW'(prod_x);
			ry_q  <= RW'(prod_y);
			cx_q  <= fx_q >> FRAC_BITS;
			cy_q  <= fy_q >> FRAC_BITS;
			dxm_q <= dx_ext - d_val;
			dxp_q <= dx_ext + d_val;
			dym_q <= dy_ext - d_val;
			dyp_q <= dy_ext + d_val;
		end else if (adv) begin
			if (!rxb[RW-1]) begin
				rx_q <= rxb;
				cx_q <= cx_q + 1'b1;
			end else if (rxa[RW-1]) begin
				rx_q <= rxc;
				cx_q <= cx_q - 1'b1;
			end else begin
				rx_q <= rxa;
			end
			if (!ryb[RW-1]) begin
				ry_q <= ryb;
				cy_q <= cy_q + 1'b1;
			end else if (rya[RW-1]) begin
				ry_q <= ryc;
				cy_q <= cy_q - 1'b1;
			end else begin
				ry_q <= rya;
			end
		end
		// Flags of the point whose map bit is being read.
		end_hit_s1 <= (cx_q == ex_q) && (cy_q == ey_q);
		inrange_s1 <= (cx_q < GW) && (cy_q < GH);
	end

	// Step counter, pipeline valid bits and clearing pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			k_q          <= '0;
			pt_valid_q   <= 1'b0;
			chk_valid_s1 <= 1'b0;
			clr_q        <= '0;
		end else begin
			if (cmd.init) begin
				n_q          <= m_q >> FRAC_BITS;
				k_q          <= '0;
				pt_valid_q   <= 1'b0;
				chk_valid_s1 <= 1'b0;
			end else begin
				if (adv) begin
					k_q <= k_q + 1'b1;
				end
				pt_valid_q   <= adv;
				chk_valid_s1 <= cmd.step && pt_valid_q;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Map write port: clearing pass or write item.
	assign wx        = COORD_W'(cell_x);
	assign wy        = COORD_W'(cell_y);
	assign wr_ok     = (wx < GW) && (wy < GH);
	assign ram_we    = cmd.clear || (cmd.write && wr_ok);
	assign ram_wdata = cmd.clear ? 1'b0 : wall_flag;
	assign ram_waddr = cmd.clear ? clr_q :
		AW'(AW'(wy[YW-1:0]) * AW'(GRID_WIDTH) + AW'(wx[XW-1:0]));
	assign ram_raddr = AW'(AW'(cy_q[YW-1:0]) * AW'(GRID_WIDTH) + AW'(cx_q[XW-1:0]));

	glc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status to the controller.
	assign sts.clear_done  = (clr_q == AW'(DEPTH - 1));
	assign sts.hit_visible = chk_valid_s1 && end_hit_s1;
	assign sts.hit_blocked = chk_valid_s1 && !end_hit_s1 && inrange_s1 && ram_rdata;
	assign sts.exhausted   = (k_q == n_q) && !pt_valid_q && !chk_valid_s1;

endmodule

FILE: design/glc_ctrl.sv
`timescale 1ns / 1ps

module glc_ctrl import glc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_opcode,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    visible,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q, visible_q, res_q;
	logic   out_free, load_out, load_val, hold_res, walk_done;

	assign out_free  = !out_valid_q || out_ready;
	assign walk_done = sts.hit_visible || sts.hit_blocked || sts.exhausted;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		load_out = 1'b0;
		load_val = 1'b0;
		hold_res = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.write = in_valid && (in_opcode == OP_WRITE);
				cmd.load  = in_valid && (in_opcode == OP_QUERY);
				if (cmd.load) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (walk_done) begin
					if (out_free) begin
						load_out = 1'b1;
						load_val = !sts.hit_blocked;
						state_d  = ST_IDLE;
					end else begin
						hold_res = 1'b1;
						state_d  = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					load_val = res_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			visible_q <= load_val;
		end
		if (hold_res) begin
			res_q <= !sts.hit_blocked;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

endmodule

FILE: design/grid_line_of_sight_check_top.sv
`timescale 1ns / 1ps
// Channel  Modport  Payload                                              Transaction
// req      sink     opcode, cell_x, cell_y, wall_flag, from/to x and y   valid && ready
// rsp      source   visible                                              valid && ready
//
// A write gives no result. A query answers once its walk reaches the end cell, meets a
// wall cell or runs out of points; the ray advances one map read per cycle.
// After reset a clearing pass writes every map cell (GRID_WIDTH * GRID_HEIGHT, 4096 by
// default) while req.ready stays low. A result waits in the output register while
// rsp.ready is low; a query that finishes meanwhile holds until it is free.

module grid_line_of_sight_check_top import glc_pkg::*; #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int FRAC_BITS   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	glc_req_if.sink   req,
	glc_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    req_ready, rsp_valid, rsp_visible;

	// Sequencer for clearing, writes and the ray walk.
	glc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req_ready),
		.out_valid (rsp_valid),
		.out_ready (rsp.ready),
		.visible   (rsp_visible),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Map storage and ray arithmetic.
	glc_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cell_x    (req.cell_x),
		.cell_y    (req.cell_y),
		.wall_flag (req.wall_flag),
		.from_x    (req.from_x),
		.from_y    (req.from_y),
		.to_x      (req.to_x),
		.to_y      (req.to_y),
		.sts       (sts)
	);

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.visible = rsp_visible;

`ifndef SYNTH
	// An accepted query starts its setup in the next cycle.
	a_query_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == OP_QUERY) |=> cmd.prep)
		else $error("accepted query did not start setup");

	// At most one walk outcome at a time.
	a_sts_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({sts.hit_visible, sts.hit_blocked, sts.exhausted}))
		else $error("conflicting walk outcomes");

	// No transaction is taken during the clearing pass.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !req.ready)
		else $error("request taken during map clearing");
`endif

endmodule
